@@ design/drtt_pkg.sv @@
// Shared types, widths, constants and helper functions of the rank timing tracker.
// Used by every other file of the design; depends on nothing.
package drtt_pkg;

    localparam int BANKS     = 8;
    localparam int FAW_DEPTH = 4;
    localparam int T_RTRS    = 1;
    localparam int T_OST     = 1;

    localparam int KIND_W    = 4;
    localparam int NOW_W     = 48;
    localparam int TIME_W    = 49;
    localparam int SUM_W     = 48;
    localparam int CALC_W    = TIME_W + 1;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = $clog2(BANKS + 1);

    typedef logic signed [CALC_W-1:0] stime_t;
    typedef logic [SUM_W-1:0]         sum_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [KIND_W-1:0] {
        K_OBSERVE     = 4'd0,
        K_ACTIVATE    = 4'd1,
        K_PRECHARGE   = 4'd2,
        K_AUTO_PRE    = 4'd3,
        K_READ        = 4'd4,
        K_WRITE       = 4'd5,
        K_REFRESH     = 4'd6,
        K_OTHER_READ  = 4'd7,
        K_OTHER_WRITE = 4'd8,
        K_CLEAR_WIN   = 4'd9,
        K_REBASE      = 4'd10
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_T_RRD   = 3'd0,
        CFG_T_FAW   = 3'd1,
        CFG_T_RP    = 3'd2,
        CFG_T_RFC   = 3'd3,
        CFG_T_BURST = 3'd4,
        CFG_T_CAS   = 3'd5,
        CFG_T_CWD   = 3'd6,
        CFG_T_WTR   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] t_rrd;
        logic [CFG_W-1:0] t_faw;
        logic [CFG_W-1:0] t_rp;
        logic [CFG_W-1:0] t_rfc;
        logic [CFG_W-1:0] t_burst;
        logic [CFG_W-1:0] t_cas;
        logic [CFG_W-1:0] t_cwd;
        logic [CFG_W-1:0] t_wtr;
    } cfg_t;

    typedef struct packed {
        stime_t ea;
        stime_t er;
        stime_t ew;
        stime_t ef;
        stime_t lap;
        stime_t ws;
        sum_t   wsum;
        sum_t   tsum;
        cnt_t   pcnt;
    } track_t;

    localparam cfg_t CFG_RESET = '{
        t_rrd: 12'd4, t_faw: 12'd20, t_rp: 12'd5, t_rfc: 12'd51,
        t_burst: 12'd4, t_cas: 12'd5, t_cwd: 12'd4, t_wtr: 12'd3
    };

    localparam stime_t RESET_MARK = stime_t'(-100);
    localparam stime_t TIME_MAX   = stime_t'({TIME_W{1'b1}});
    localparam sum_t   SUM_MAX    = '1;
    localparam cnt_t   CNT_FULL   = cnt_t'(BANKS);

    function automatic stime_t ext_cfg(input logic [CFG_W-1:0] v);
        return stime_t'(v);
    endfunction

    function automatic stime_t ext_now(input logic [NOW_W-1:0] v);
        return stime_t'(v);
    endfunction

    function automatic stime_t tmax(input stime_t a, input stime_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic stime_t tsat(input stime_t a);
        return (a > TIME_MAX) ? TIME_MAX : a;
    endfunction

    // b is never negative here
    function automatic sum_t sum_sat(input sum_t a, input stime_t b);
        logic [CALC_W-1:0] s;
        s = CALC_W'(a) + CALC_W'(unsigned'(b));
        return (s > CALC_W'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic stime_t run_interval(input stime_t now, input stime_t ws,
                                            input stime_t lap);
        stime_t d;
        d = now - tmax(ws, lap);
        return (d > 0) ? d : '0;
    endfunction

endpackage

@@ design/drtt_if.sv @@
// Valid/ready channel interfaces for command beats and result beats.
// Depends on drtt_pkg for field widths.
interface drtt_cmd_if import drtt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [NOW_W-1:0]  now_time;
    logic [NOW_W-1:0]  bank_precharge_time;

    modport source (output valid, kind, now_time, bank_precharge_time, input ready);
    modport sink   (input valid, kind, now_time, bank_precharge_time, output ready);
endinterface

interface drtt_res_if import drtt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] next_activate_time;
    logic [TIME_W-1:0] next_read_time;
    logic [TIME_W-1:0] next_write_time;
    logic [TIME_W-1:0] next_refresh_time;
    logic [SUM_W-1:0]  window_precharge_time;
    logic [SUM_W-1:0]  total_precharge_time;
    logic              all_precharged;

    modport source (output valid, next_activate_time, next_read_time, next_write_time,
                    next_refresh_time, window_precharge_time, total_precharge_time,
                    all_precharged, input ready);
    modport sink   (input valid, next_activate_time, next_read_time, next_write_time,
                    next_refresh_time, window_precharge_time, total_precharge_time,
                    all_precharged, output ready);
endinterface

@@ design/dram_rank_timing_tracker.sv @@
// Rank-level DRAM command timing tracker: top level with the beat handshake.
// Depends on drtt_pkg, drtt_if, drtt_cfg, drtt_track and drtt_result.
//
//   channel  | dir | beat contents
//   ---------+-----+----------------------------------------------------------
//   cmd      | in  | kind, now_time, bank_precharge_time
//   res      | out | four next times, window/total precharge time, all_precharged
//   cfg      | in  | cfg_wr_en, cfg_index, cfg_data (write only)
//
// One command beat per cycle sustained while res.ready stays high; its result beat passes
// through the input register, the timing state update and the result register.
// The timing state update has no busy state, so consecutive commands never wait for it.
// A stalled result holds the pipe; cmd.ready drops only when all stages are full.
// Reset loads the timing defaults and the idle rank state at once; no clearing pass.
module dram_rank_timing_tracker import drtt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    drtt_cmd_if.sink             cmd,
    drtt_res_if.source           res
);

    cfg_t   cfg;
    track_t trk;

    logic             v0_reg, v1_reg, vo_reg;
    logic             v0_next, v1_next, vo_next;
    kind_t            kind_reg;
    logic [NOW_W-1:0] now0_reg, bpre0_reg, now1_reg;

    logic accept, s0_go, s1_go, s0_free, s1_free, out_free;

    assign out_free = !vo_reg || res.ready;
    assign s1_go    = v1_reg && out_free;
    assign s1_free  = !v1_reg || out_free;
    assign s0_go    = v0_reg && s1_free;
    assign s0_free  = !v0_reg || s1_free;
    assign cmd.ready = s0_free;
    assign accept   = cmd.valid && s0_free;

    always_comb
    begin
        v0_next = accept ? 1'b1 : (s0_go ? 1'b0 : v0_reg);
        v1_next = s0_go ? 1'b1 : (s1_go ? 1'b0 : v1_reg);
        vo_next = s1_go ? 1'b1 : (res.ready ? 1'b0 : vo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_t'(cmd.kind);
            now0_reg  <= cmd.now_time;
            bpre0_reg <= cmd.bank_precharge_time;
        end
        if (s0_go)
            now1_reg <= now0_reg;
    end

    drtt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    drtt_track u_track (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step                (s0_go),
        .kind                (kind_reg),
        .now_time            (now0_reg),
        .bank_precharge_time (bpre0_reg),
        .cfg                 (cfg),
        .trk                 (trk)
    );

    drtt_result u_result (
        .clk                   (clk),
        .load                  (s1_go),
        .trk                   (trk),
        .now_time              (now1_reg),
        .next_activate_time    (res.next_activate_time),
        .next_read_time        (res.next_read_time),
        .next_write_time       (res.next_write_time),
        .next_refresh_time     (res.next_refresh_time),
        .window_precharge_time (res.window_precharge_time),
        .total_precharge_time  (res.total_precharge_time),
        .all_precharged        (res.all_precharged)
    );

    assign res.valid = vo_reg;

endmodule

@@ design/drtt_cfg.sv @@
// Timing parameter registers written through the plain configuration port.
// Depends on drtt_pkg.
module drtt_cfg import drtt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_T_RRD:   cfg_next.t_rrd   = cfg_data;
                CFG_T_FAW:   cfg_next.t_faw   = cfg_data;
                CFG_T_RP:    cfg_next.t_rp    = cfg_data;
                CFG_T_RFC:   cfg_next.t_rfc   = cfg_data;
                CFG_T_BURST: cfg_next.t_burst = cfg_data;
                CFG_T_CAS:   cfg_next.t_cas   = cfg_data;
                CFG_T_CWD:   cfg_next.t_cwd   = cfg_data;
                CFG_T_WTR:   cfg_next.t_wtr   = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

@@ design/drtt_track.sv @@
// Rank timing state: activate history, earliest command times, precharge accounting.
// Updated once per command beat; depends on drtt_pkg.
module drtt_track import drtt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  kind_t            kind,
    input  logic [NOW_W-1:0] now_time,
    input  logic [NOW_W-1:0] bank_precharge_time,
    input  cfg_t             cfg,
    output track_t           trk
);

    stime_t hist_reg  [FAW_DEPTH];
    stime_t hist_next [FAW_DEPTH];
    track_t trk_reg;
    track_t trk_next;

    stime_t now_s;
    stime_t bpre_s;
    stime_t rrd, faw, rp, rfc, bur, cas, cwd, wtr;
    stime_t run_d;
    stime_t lap_new;

    always_comb
    begin
        now_s  = ext_now(now_time);
        bpre_s = ext_now(bank_precharge_time);
        rrd    = ext_cfg(cfg.t_rrd);
        faw    = ext_cfg(cfg.t_faw);
        rp     = ext_cfg(cfg.t_rp);
        rfc    = ext_cfg(cfg.t_rfc);
        bur    = ext_cfg(cfg.t_burst);
        cas    = ext_cfg(cfg.t_cas);
        cwd    = ext_cfg(cfg.t_cwd);
        wtr    = ext_cfg(cfg.t_wtr);
        run_d  = run_interval(now_s, trk_reg.ws, trk_reg.lap);
        lap_new = (kind == K_AUTO_PRE) ? tmax(trk_reg.lap, bpre_s)
                                       : tmax(trk_reg.lap, now_s);

        hist_next = hist_reg;
        trk_next  = trk_reg;

        unique case (kind)
            K_ACTIVATE:
            begin
                for (int i = FAW_DEPTH - 1; i > 0; i--)
                    hist_next[i] = hist_reg[i-1];
                hist_next[0] = now_s;
                if (trk_reg.pcnt == CNT_FULL)
                begin
                    trk_next.wsum = sum_sat(trk_reg.wsum, run_d);
                    trk_next.tsum = sum_sat(trk_reg.tsum, run_d);
                end
                if (trk_reg.pcnt != '0)
                    trk_next.pcnt = trk_reg.pcnt - cnt_t'(1);
                trk_next.ea = tsat(tmax(now_s + rrd,
                                   tmax(hist_reg[FAW_DEPTH-2] + faw, trk_reg.ea)));
            end
            K_PRECHARGE, K_AUTO_PRE:
            begin
                trk_next.lap = lap_new;
                if (trk_reg.pcnt != CNT_FULL)
                    trk_next.pcnt = trk_reg.pcnt + cnt_t'(1);
                trk_next.ef = tsat(tmax(trk_reg.ef, lap_new + rp));
            end
            K_READ:
            begin
                trk_next.er = tsat(tmax(trk_reg.er, now_s + bur));
                trk_next.ew = tsat(tmax(trk_reg.ew,
                                   now_s + cas + bur + stime_t'(T_RTRS) - cwd));
            end
            K_WRITE:
            begin
                trk_next.er = tsat(tmax(trk_reg.er, now_s + cwd + bur + wtr));
                trk_next.ew = tsat(tmax(trk_reg.ew, now_s + bur));
            end
            K_REFRESH:
            begin
                trk_next.ef = tsat(tmax(trk_reg.ef, now_s + rfc));
                trk_next.ea = tsat(tmax(trk_reg.ea, now_s + rfc));
            end
            K_OTHER_READ:
            begin
                trk_next.er = tsat(tmax(trk_reg.er, now_s + bur + stime_t'(T_RTRS)));
                trk_next.ew = tsat(tmax(trk_reg.ew,
                                   now_s + cas + bur + stime_t'(T_RTRS) - cwd));
            end
            K_OTHER_WRITE:
            begin
                trk_next.er = tsat(tmax(trk_reg.er,
                                   now_s + cwd + bur + stime_t'(T_RTRS) - cas));
                trk_next.ew = tsat(tmax(trk_reg.ew, now_s + stime_t'(T_OST) + bur));
            end
            K_CLEAR_WIN:
            begin
                trk_next.wsum = '0;
                trk_next.ws   = now_s;
            end
            K_REBASE:
            begin
                trk_next.lap  = now_s;
                trk_next.ws   = now_s;
                trk_next.wsum = '0;
                trk_next.ea   = now_s;
                trk_next.ef   = tsat(now_s + rp);
                for (int i = 0; i < FAW_DEPTH; i++)
                    hist_next[i] = now_s - faw;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FAW_DEPTH; i++)
                hist_reg[i] <= RESET_MARK;
            trk_reg.ea   <= '0;
            trk_reg.er   <= '0;
            trk_reg.ew   <= '0;
            trk_reg.ef   <= '0;
            trk_reg.lap  <= RESET_MARK;
            trk_reg.ws   <= '0;
            trk_reg.wsum <= '0;
            trk_reg.tsum <= '0;
            trk_reg.pcnt <= CNT_FULL;
        end
        else if (step)
        begin
            hist_reg <= hist_next;
            trk_reg  <= trk_next;
        end
    end

    assign trk = trk_reg;

endmodule

@@ design/drtt_result.sv @@
// Result stage: adds the running all-precharged interval and holds the result beat.
// Depends on drtt_pkg.
module drtt_result import drtt_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  track_t            trk,
    input  logic [NOW_W-1:0]  now_time,
    output logic [TIME_W-1:0] next_activate_time,
    output logic [TIME_W-1:0] next_read_time,
    output logic [TIME_W-1:0] next_write_time,
    output logic [TIME_W-1:0] next_refresh_time,
    output sum_t              window_precharge_time,
    output sum_t              total_precharge_time,
    output logic              all_precharged
);

    logic              allpre;
    stime_t            extra;
    logic [TIME_W-1:0] ea_reg, er_reg, ew_reg, ef_reg;
    sum_t              wsum_reg, tsum_reg;
    sum_t              wsum_next, tsum_next;
    logic              allpre_reg;

    always_comb
    begin
        allpre    = (trk.pcnt == CNT_FULL);
        extra     = allpre ? run_interval(ext_now(now_time), trk.ws, trk.lap) : '0;
        wsum_next = sum_sat(trk.wsum, extra);
        tsum_next = sum_sat(trk.tsum, extra);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ea_reg     <= trk.ea[TIME_W-1:0];
            er_reg     <= trk.er[TIME_W-1:0];
            ew_reg     <= trk.ew[TIME_W-1:0];
            ef_reg     <= trk.ef[TIME_W-1:0];
            wsum_reg   <= wsum_next;
            tsum_reg   <= tsum_next;
            allpre_reg <= allpre;
        end
    end

    assign next_activate_time    = ea_reg;
    assign next_read_time        = er_reg;
    assign next_write_time       = ew_reg;
    assign next_refresh_time     = ef_reg;
    assign window_precharge_time = wsum_reg;
    assign total_precharge_time  = tsum_reg;
    assign all_precharged        = allpre_reg;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for dram_rank_timing_tracker: random and directed command
// beats, a timing predictor of the rank, and a beat-by-beat result check.
// Depends on drtt_pkg, drtt_if and the tracker RTL.
module tb;
    import drtt_pkg::*;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [NOW_W-1:0]  now;
        logic [NOW_W-1:0]  bpre;
    } rank_cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] next_act;
        logic [TIME_W-1:0] next_rd;
        logic [TIME_W-1:0] next_wr;
        logic [TIME_W-1:0] next_rfsh;
        logic [SUM_W-1:0]  win_sum;
        logic [SUM_W-1:0]  tot_sum;
        logic              all_pre;
    } rank_timing_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    drtt_cmd_if cmd ();
    drtt_res_if res ();

    dram_rank_timing_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .res       (res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rank_cmd_t    cmd_pending[$];
    rank_timing_t timing_expect[$];
    rank_cmd_t    drive_beat;
    logic         cmd_taken;
    int           results_seen;
    int           mismatch_count;
    logic         hold_done;
    int           hold_left;
    logic         quiet;
    logic [NOW_W-1:0] tick;

    assign quiet = (results_seen >= 900) && (results_seen < 1300);

    // predictor state
    logic [CFG_W-1:0] timing_cfg [8];
    stime_t act_hist [FAW_DEPTH];
    stime_t ea, er, ew, ef, lap, ws;
    sum_t   wsum, tsum;
    int     precharged_cnt;

    function automatic stime_t widen(input logic [CFG_W-1:0] v);
        return stime_t'({{(CALC_W-CFG_W){1'b0}}, v});
    endfunction

    function automatic stime_t latest(input stime_t a, input stime_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic stime_t clip_time(input stime_t a);
        return (a > TIME_MAX) ? TIME_MAX : a;
    endfunction

    function automatic sum_t sat_sum(input sum_t a, input stime_t b);
        logic [CALC_W-1:0] s;
        s = {2'b00, a} + b;
        return (s > {2'b00, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic stime_t idle_span(input stime_t now_s);
        stime_t d;
        d = now_s - latest(ws, lap);
        return (d > 0) ? d : '0;
    endfunction

    task automatic reset_rank_model();
        timing_cfg[CFG_T_RRD]   = CFG_RESET.t_rrd;
        timing_cfg[CFG_T_FAW]   = CFG_RESET.t_faw;
        timing_cfg[CFG_T_RP]    = CFG_RESET.t_rp;
        timing_cfg[CFG_T_RFC]   = CFG_RESET.t_rfc;
        timing_cfg[CFG_T_BURST] = CFG_RESET.t_burst;
        timing_cfg[CFG_T_CAS]   = CFG_RESET.t_cas;
        timing_cfg[CFG_T_CWD]   = CFG_RESET.t_cwd;
        timing_cfg[CFG_T_WTR]   = CFG_RESET.t_wtr;
        for (int i = 0; i < FAW_DEPTH; i++)
            act_hist[i] = RESET_MARK;
        ea = '0;
        er = '0;
        ew = '0;
        ef = '0;
        lap = RESET_MARK;
        ws = '0;
        wsum = '0;
        tsum = '0;
        precharged_cnt = BANKS;
    endtask

    function automatic rank_timing_t predict_rank(input logic [KIND_W-1:0] kind,
                                                  input logic [NOW_W-1:0] now,
                                                  input logic [NOW_W-1:0] bpre);
        stime_t now_s, bpre_s, rrd, faw, rp, rfc, bur, cas, cwd, wtr, span;
        rank_timing_t r;
        now_s  = stime_t'({2'b00, now});
        bpre_s = stime_t'({2'b00, bpre});
        rrd = widen(timing_cfg[CFG_T_RRD]);
        faw = widen(timing_cfg[CFG_T_FAW]);
        rp  = widen(timing_cfg[CFG_T_RP]);
        rfc = widen(timing_cfg[CFG_T_RFC]);
        bur = widen(timing_cfg[CFG_T_BURST]);
        cas = widen(timing_cfg[CFG_T_CAS]);
        cwd = widen(timing_cfg[CFG_T_CWD]);
        wtr = widen(timing_cfg[CFG_T_WTR]);
        case (kind)
            K_ACTIVATE:
            begin
                for (int i = FAW_DEPTH - 1; i > 0; i--)
                    act_hist[i] = act_hist[i-1];
                act_hist[0] = now_s;
                if (precharged_cnt == BANKS)
                begin
                    span = idle_span(now_s);
                    wsum = sat_sum(wsum, span);
                    tsum = sat_sum(tsum, span);
                end
                if (precharged_cnt > 0)
                    precharged_cnt--;
                ea = clip_time(latest(now_s + rrd, latest(act_hist[FAW_DEPTH-1] + faw, ea)));
            end
            K_PRECHARGE, K_AUTO_PRE:
            begin
                lap = latest(lap, (kind == K_AUTO_PRE) ? bpre_s : now_s);
                if (precharged_cnt < BANKS)
                    precharged_cnt++;
                ef = clip_time(latest(ef, lap + rp));
            end
            K_READ:
            begin
                er = clip_time(latest(er, now_s + bur));
                ew = clip_time(latest(ew, now_s + cas + bur + T_RTRS - cwd));
            end
            K_WRITE:
            begin
                er = clip_time(latest(er, now_s + cwd + bur + wtr));
                ew = clip_time(latest(ew, now_s + bur));
            end
            K_REFRESH:
            begin
                ef = clip_time(latest(ef, now_s + rfc));
                ea = clip_time(latest(ea, now_s + rfc));
            end
            K_OTHER_READ:
            begin
                er = clip_time(latest(er, now_s + bur + T_RTRS));
                ew = clip_time(latest(ew, now_s + cas + bur + T_RTRS - cwd));
            end
            K_OTHER_WRITE:
            begin
                er = clip_time(latest(er, now_s + cwd + bur + T_RTRS - cas));
                ew = clip_time(latest(ew, now_s + T_OST + bur));
            end
            K_CLEAR_WIN:
            begin
                wsum = '0;
                ws = now_s;
            end
            K_REBASE:
            begin
                lap = now_s;
                ws = now_s;
                wsum = '0;
                ea = now_s;
                ef = clip_time(now_s + rp);
                for (int i = 0; i < FAW_DEPTH; i++)
                    act_hist[i] = now_s - faw;
            end
            default:
            begin
            end
        endcase
        span = (precharged_cnt == BANKS) ? idle_span(now_s) : '0;
        r.next_act  = ea[TIME_W-1:0];
        r.next_rd   = er[TIME_W-1:0];
        r.next_wr   = ew[TIME_W-1:0];
        r.next_rfsh = ef[TIME_W-1:0];
        r.win_sum   = sat_sum(wsum, span);
        r.tot_sum   = sat_sum(tsum, span);
        r.all_pre   = (precharged_cnt == BANKS);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
        end
    endtask

    // driver: hold a beat until taken, then advance
    always @(negedge clk)
    begin
        if (rst_n && (!cmd.valid || cmd_taken))
        begin
            if (cmd_pending.size() > 0 && (quiet || $urandom_range(0, 99) >= 27))
            begin
                drive_beat = cmd_pending.pop_front();
                cmd.valid               <= 1'b1;
                cmd.kind                <= drive_beat.kind;
                cmd.now_time            <= drive_beat.now;
                cmd.bank_precharge_time <= drive_beat.bpre;
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // receiver: one long hold-off, otherwise random stalls outside the quiet window
    always @(negedge clk)
    begin
        if (!hold_done && results_seen >= 400)
        begin
            hold_done <= 1'b1;
            hold_left <= 150;
            res.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else
            res.ready <= quiet || ($urandom_range(0, 99) >= 27);
    end

    // monitor
    always @(posedge clk)
    begin
        rank_timing_t want;
        cmd_taken <= rst_n && cmd.valid && cmd.ready;
        if (rst_n && cmd.valid && cmd.ready)
            timing_expect.push_back(predict_rank(cmd.kind, cmd.now_time,
                                                 cmd.bank_precharge_time));
        if (rst_n && res.valid && res.ready)
        begin
            results_seen <= results_seen + 1;
            if (timing_expect.size() == 0)
            begin
                mismatch_count++;
                $display("%0t unexpected result beat: expected none actual %h", $time,
                         res.next_activate_time);
            end
            else
            begin
                want = timing_expect.pop_front();
                check_field("next_activate_time", want.next_act, res.next_activate_time);
                check_field("next_read_time", want.next_rd, res.next_read_time);
                check_field("next_write_time", want.next_wr, res.next_write_time);
                check_field("next_refresh_time", want.next_rfsh, res.next_refresh_time);
                check_field("window_precharge_time", TIME_W'(want.win_sum),
                            TIME_W'(res.window_precharge_time));
                check_field("total_precharge_time", TIME_W'(want.tot_sum),
                            TIME_W'(res.total_precharge_time));
                check_field("all_precharged", TIME_W'(want.all_pre),
                            TIME_W'(res.all_precharged));
            end
        end
    end

    function automatic logic [NOW_W-1:0] rand48();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    task automatic push_cmd(input logic [KIND_W-1:0] kind, input logic [NOW_W-1:0] now,
                            input logic [NOW_W-1:0] bpre);
        rank_cmd_t c;
        c.kind = kind;
        c.now  = now;
        c.bpre = bpre;
        cmd_pending.push_back(c);
    endtask

    task automatic push_at_tick(input logic [KIND_W-1:0] kind);
        tick = tick + NOW_W'($urandom_range(0, 40));
        push_cmd(kind, tick, ($urandom_range(0, 9) == 0) ? rand48() :
                 tick - NOW_W'($urandom_range(0, 30)) + NOW_W'($urandom_range(0, 30)));
    endtask

    task automatic gen_traffic(input int count);
        int start, nb, nrw, r;
        logic [KIND_W-1:0] rw_kind [4];
        rw_kind[0] = K_READ;
        rw_kind[1] = K_WRITE;
        rw_kind[2] = K_OTHER_READ;
        rw_kind[3] = K_OTHER_WRITE;
        start = cmd_pending.size();
        while (cmd_pending.size() - start < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                nb = $urandom_range(1, BANKS + 1);
                for (int j = 0; j < nb; j++)
                begin
                    push_at_tick(K_ACTIVATE);
                    if ($urandom_range(0, 2) == 0)
                        push_at_tick(rw_kind[$urandom_range(0, 3)]);
                end
                nrw = $urandom_range(0, 6);
                for (int j = 0; j < nrw; j++)
                    push_at_tick(rw_kind[$urandom_range(0, 3)]);
                for (int j = 0; j < nb; j++)
                    push_at_tick(($urandom_range(0, 1) == 0) ? K_PRECHARGE : K_AUTO_PRE);
                if ($urandom_range(0, 1) == 0)
                    push_at_tick(K_REFRESH);
                if ($urandom_range(0, 9) == 0)
                    push_at_tick(K_CLEAR_WIN);
                if ($urandom_range(0, 9) == 0)
                    push_at_tick(K_OBSERVE);
            end
            else if (r < 95)
                push_cmd(KIND_W'($urandom_range(0, 15)),
                         ($urandom_range(0, 1) == 0) ? tick : rand48(), rand48());
            else if (r < 98)
                push_at_tick(K_REBASE);
            else
                tick = ($urandom_range(0, 1) == 0) ? rand48() : ~NOW_W'($urandom_range(0, 500));
        end
    endtask

    task automatic wait_idle();
        int n;
        n = 0;
        while ((cmd_pending.size() != 0 || cmd.valid || timing_expect.size() != 0)
               && n < 20000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic program_timing(input logic [CFG_W-1:0] vals [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            timing_cfg[i] = vals[i];
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [CFG_W-1:0] vals [8];
        logic [NOW_W-1:0] top;
        cmd.valid = 1'b0;
        cmd.kind = '0;
        cmd.now_time = '0;
        cmd.bank_precharge_time = '0;
        res.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_taken = 1'b0;
        results_seen = 0;
        mismatch_count = 0;
        hold_done = 1'b0;
        hold_left = 0;
        tick = '0;
        top = '1;
        reset_rank_model();
        rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_cmd(K_PRECHARGE, 48'd5, '0);
        push_cmd(K_OBSERVE, '0, '0);
        push_cmd(K_AUTO_PRE, 48'd3, 48'd2);
        push_cmd(K_ACTIVATE, top, '0);
        push_cmd(K_READ, top, top);
        push_cmd(K_WRITE, top, '0);
        push_cmd(K_OTHER_READ, top, '0);
        push_cmd(K_OTHER_WRITE, top, '0);
        push_cmd(K_PRECHARGE, top, '0);
        push_cmd(K_REBASE, '0, '0);
        push_cmd(K_ACTIVATE, top, top);
        push_cmd(K_AUTO_PRE, '0, top);
        push_cmd(K_REFRESH, top, '0);
        push_cmd(K_CLEAR_WIN, '0, '0);
        for (int k = K_REBASE + 1; k < 16; k++)
            push_cmd(KIND_W'(k), top, top);
        push_cmd(K_OBSERVE, top, '0);
        push_cmd(K_REBASE, top, '0);
        push_cmd(K_ACTIVATE, '0, '0);
        push_cmd(K_REBASE, '0, '0);
        gen_traffic(300);
        wait_idle();

        for (int p = 1; p < 6; p++)
        begin
            for (int i = 0; i < 8; i++)
                case (p)
                    1: vals[i] = '0;
                    2: vals[i] = '1;
                    3: vals[i] = CFG_W'($urandom_range(0, 4095));
                    default: vals[i] = CFG_W'($urandom_range(0, 63));
                endcase
            program_timing(vals);
            tick = '0;
            push_cmd(K_REBASE, '0, '0);
            gen_traffic(300);
            wait_idle();
        end

        if (timing_expect.size() != 0)
        begin
            mismatch_count++;
            $display("%0t leftover results: expected %0d actual 0", $time,
                     timing_expect.size());
        end
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[dram_rank_timing_tracker] OK");
        else
            $display("[dram_rank_timing_tracker] ERROR");
        $finish;
    end

    initial
    begin
        #(8 * 400000);
        $display("[dram_rank_timing_tracker] ERROR");
        $finish;
    end

endmodule
